[rtl/core/assert_macros.svh]
// Assertion macros used by dpaq_checker.
// Depends on nothing; the user supplies clock, reset, property terms and message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/dpaq_pkg.sv]
// Package for the dual priority action queue: beat structs, codes, FSM state.
// No dependencies; every other file but assert_macros.svh uses it by scoped names.
package dpaq_pkg;

  // Operation codes carried in cmd_t.operation
  localparam logic [2:0] OP_PUSH       = 3'd0;
  localparam logic [2:0] OP_POP        = 3'd1;
  localparam logic [2:0] OP_PEEK       = 3'd2;
  localparam logic [2:0] OP_DELETE     = 3'd3;
  localparam logic [2:0] OP_SET_EXP    = 3'd4;
  localparam logic [2:0] OP_SET_NORMAL = 3'd5;

  // Input beat
  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] action_in;
    logic [7:0] position;
  } cmd_t;

  // Result beat
  typedef struct packed {
    logic [7:0] action_out;
    logic       push_accepted;
    logic [2:0] expedited_count;
    logic [4:0] normal_count;
    logic       expedited_mode;
  } res_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  // Source of the result action code
  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_EMPTY,
    SRC_EXP,
    SRC_NRM
  } src_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
    logic respond;
  } ctrl_t;

endpackage

[rtl/core/dual_priority_action_queue_top.sv]
// Top level of the dual priority action queue: controller plus datapath.
// Depends on dpaq_pkg, dpaq_controller and dpaq_datapath.
//
//   Channel   Handshake            Payload
//   command   start / busy         cmd    (dpaq_pkg::cmd_t)
//   result    done (one cycle)     result (dpaq_pkg::res_t)
//   config    cfg_we               cfg_data (empty code)
//
// Each command is accepted in ST_IDLE, then passes through ST_EXEC (pointer
// update and store access with registered read) and ST_RESP, where done is
// high; only then can the next command be accepted. Reset clears pointers,
// mode and empty code; the stores need no clearing. The receiver cannot
// stall; busy is high in ST_EXEC and ST_RESP, from after the accept edge
// through the result cycle.
module dual_priority_action_queue_top #(
  parameter int EXPEDITED_DEPTH = 8,
  parameter int NORMAL_DEPTH    = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  dpaq_pkg::cmd_t cmd,
  output logic           done,
  output dpaq_pkg::res_t result,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_data
);

  dpaq_pkg::ctrl_t ctrl;

  dpaq_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  dpaq_datapath #(
    .EXPEDITED_DEPTH (EXPEDITED_DEPTH),
    .NORMAL_DEPTH    (NORMAL_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .cmd      (cmd),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .result   (result)
  );

  // Result strobe on the response cycle
  assign done = ctrl.respond;

endmodule

[rtl/core/dpaq_controller.sv]
// Sequencing FSM for the dual priority action queue: accept, execute, respond.
// Depends on dpaq_pkg.
module dpaq_controller (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output dpaq_pkg::ctrl_t ctrl
);

  dpaq_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dpaq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: idle, then execute, then respond
  always_comb begin
    state_next = state;
    case (state)
      dpaq_pkg::ST_IDLE: begin
        if (start) state_next = dpaq_pkg::ST_EXEC;
      end
      dpaq_pkg::ST_EXEC: begin
        state_next = dpaq_pkg::ST_RESP;
      end
      dpaq_pkg::ST_RESP: begin
        state_next = dpaq_pkg::ST_IDLE;
      end
      default: begin
        state_next = dpaq_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs: datapath commands and busy
  always_comb begin
    ctrl = '0;
    busy = 1'b1;
    case (state)
      dpaq_pkg::ST_IDLE: begin
        busy      = 1'b0;
        ctrl.load = start;
      end
      dpaq_pkg::ST_EXEC: begin
        ctrl.exec = 1'b1;
      end
      dpaq_pkg::ST_RESP: begin
        ctrl.respond = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

[rtl/core/dpaq_datapath.sv]
// Datapath for the dual priority action queue: both stores, pointers, mode
// flag, empty code register and result formation. Depends on dpaq_pkg.
module dpaq_datapath #(
  parameter int EXPEDITED_DEPTH = 8,
  parameter int NORMAL_DEPTH    = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  dpaq_pkg::ctrl_t ctrl,
  input  dpaq_pkg::cmd_t  cmd,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_data,
  output dpaq_pkg::res_t  result
);

  localparam int EW   = $clog2(EXPEDITED_DEPTH);
  localparam int NW   = $clog2(NORMAL_DEPTH);
  localparam int EPAD = 8 - EW;
  localparam int NPAD = 8 - NW;

  dpaq_pkg::cmd_t cmd_q;
  logic [7:0]     empty_code;
  logic [EW-1:0]  exp_head, exp_head_next, exp_tail, exp_tail_next;
  logic [NW-1:0]  nrm_head, nrm_head_next, nrm_tail, nrm_tail_next;
  logic           mode, mode_next;
  dpaq_pkg::src_t src, src_next;
  logic           accepted, accepted_next;

  logic [7:0] exp_mem [EXPEDITED_DEPTH];
  logic [7:0] nrm_mem [NORMAL_DEPTH];
  logic [7:0] exp_rdata, nrm_rdata;

  logic          exp_we, nrm_we;
  logic [EW-1:0] exp_waddr, exp_raddr;
  logic [NW-1:0] nrm_waddr, nrm_raddr;
  logic [7:0]    exp_wdata, nrm_wdata;

  logic [EW-1:0] exp_cnt, exp_slot;
  logic [NW-1:0] nrm_cnt, nrm_slot;
  logic [7:0]    exp_cnt8, nrm_cnt8, rem;
  logic          in_exp, in_nrm, exp_full, nrm_full;
  logic [EW+7:0] exp_cnt_wide;
  logic [NW+7:0] nrm_cnt_wide;

  // Capture the command beat and the empty code
  always_ff @(posedge clk) begin
    if (ctrl.load) cmd_q <= cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      empty_code <= '0;
    end else if (cfg_we) begin
      empty_code <= cfg_data;
    end
  end

  // Occupancy, full flags and combined-position lookup
  always_comb begin
    exp_cnt  = exp_tail - exp_head;
    nrm_cnt  = nrm_tail - nrm_head;
    exp_full = (exp_tail + EW'(1)) == exp_head;
    nrm_full = (nrm_tail + NW'(1)) == nrm_head;
    exp_cnt8 = {{EPAD{1'b0}}, exp_cnt};
    nrm_cnt8 = {{NPAD{1'b0}}, nrm_cnt};
    in_exp   = cmd_q.position < exp_cnt8;
    rem      = cmd_q.position - exp_cnt8;
    in_nrm   = !in_exp && (rem < nrm_cnt8);
    exp_slot = exp_head + cmd_q.position[EW-1:0];
    nrm_slot = nrm_head + rem[NW-1:0];
  end

  // Decode the operation into pointer, store and flag updates
  always_comb begin
    exp_head_next = exp_head;
    exp_tail_next = exp_tail;
    nrm_head_next = nrm_head;
    nrm_tail_next = nrm_tail;
    mode_next     = mode;
    src_next      = dpaq_pkg::SRC_ZERO;
    accepted_next = 1'b0;
    exp_we        = 1'b0;
    nrm_we        = 1'b0;
    exp_waddr     = exp_tail;
    nrm_waddr     = nrm_tail;
    exp_wdata     = cmd_q.action_in;
    nrm_wdata     = cmd_q.action_in;
    exp_raddr     = exp_head;
    nrm_raddr     = nrm_head;
    case (cmd_q.operation)
      dpaq_pkg::OP_PUSH: begin
        if (mode) begin
          if (!exp_full) begin
            exp_we        = 1'b1;
            exp_tail_next = exp_tail + EW'(1);
            accepted_next = 1'b1;
          end
        end else if (!nrm_full) begin
          nrm_we        = 1'b1;
          nrm_tail_next = nrm_tail + NW'(1);
          accepted_next = 1'b1;
        end
      end
      dpaq_pkg::OP_POP: begin
        if (exp_cnt != '0) begin
          src_next      = dpaq_pkg::SRC_EXP;
          exp_head_next = exp_head + EW'(1);
        end else if (nrm_cnt != '0) begin
          src_next      = dpaq_pkg::SRC_NRM;
          nrm_head_next = nrm_head + NW'(1);
        end else begin
          src_next = dpaq_pkg::SRC_EMPTY;
        end
      end
      dpaq_pkg::OP_PEEK: begin
        exp_raddr = exp_slot;
        nrm_raddr = nrm_slot;
        if (in_exp) begin
          src_next = dpaq_pkg::SRC_EXP;
        end else if (in_nrm) begin
          src_next = dpaq_pkg::SRC_NRM;
        end else begin
          src_next = dpaq_pkg::SRC_EMPTY;
        end
      end
      dpaq_pkg::OP_DELETE: begin
        exp_waddr = exp_slot;
        nrm_waddr = nrm_slot;
        exp_wdata = empty_code;
        nrm_wdata = empty_code;
        if (in_exp) begin
          exp_we = 1'b1;
        end else if (in_nrm) begin
          nrm_we = 1'b1;
        end
      end
      dpaq_pkg::OP_SET_EXP: begin
        mode_next = 1'b1;
      end
      dpaq_pkg::OP_SET_NORMAL: begin
        mode_next = 1'b0;
      end
      default: begin
        mode_next = mode;
      end
    endcase
  end

  // Advance pointers and mode on the execute cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_head <= '0;
      exp_tail <= '0;
      nrm_head <= '0;
      nrm_tail <= '0;
      mode     <= 1'b0;
    end else if (ctrl.exec) begin
      exp_head <= exp_head_next;
      exp_tail <= exp_tail_next;
      nrm_head <= nrm_head_next;
      nrm_tail <= nrm_tail_next;
      mode     <= mode_next;
    end
  end

  // Hold result selectors for the response cycle
  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      src      <= src_next;
      accepted <= accepted_next;
    end
  end

  // Expedited store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctrl.exec && exp_we) exp_mem[exp_waddr] <= exp_wdata;
    if (ctrl.exec) exp_rdata <= exp_mem[exp_raddr];
  end

  // Normal store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctrl.exec && nrm_we) nrm_mem[nrm_waddr] <= nrm_wdata;
    if (ctrl.exec) nrm_rdata <= nrm_mem[nrm_raddr];
  end

  // Form the result beat from updated state and read data
  always_comb begin
    exp_cnt_wide = {8'd0, exp_cnt};
    nrm_cnt_wide = {8'd0, nrm_cnt};
    result.push_accepted   = accepted;
    result.expedited_count = exp_cnt_wide[2:0];
    result.normal_count    = nrm_cnt_wide[4:0];
    result.expedited_mode  = mode;
    case (src)
      dpaq_pkg::SRC_EMPTY: result.action_out = empty_code;
      dpaq_pkg::SRC_EXP:   result.action_out = exp_rdata;
      dpaq_pkg::SRC_NRM:   result.action_out = nrm_rdata;
      default:             result.action_out = 8'd0;
    endcase
  end

endmodule

[rtl/core/dpaq_checker.sv]
// Port-level checker for the dual priority action queue, bound to the top.
// Depends on dpaq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dpaq_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input dpaq_pkg::res_t result
);

  // Accepted beat raises busy after the accept edge
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, start && !busy, busy, "busy not raised")

  // Result follows acceptance after ST_EXEC, in ST_RESP
  `ASSERT_IMPLIES(a_result_latency, clk, rst, start && !busy, ##2 done, "result late")

  // Result strobe lasts one cycle
  `ASSERT_NEXT(a_done_single, clk, rst, done, !done, "done held too long")

  // A stored push never reports an action code
  `ASSERT_IMPLIES(a_push_no_action, clk, rst, done && result.push_accepted,
                  result.action_out == 8'd0, "push reported an action")

endmodule

bind dual_priority_action_queue_top dpaq_checker u_dpaq_checker (.*);

[sim/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for dual_priority_action_queue_top: a directed table, then
// random phases under several empty codes. Depends on dpaq_pkg and the RTL top.
module tb;

  localparam int EXP_DEPTH = 8;
  localparam int NRM_DEPTH = 32;
  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT = 200;
  localparam int MAX_REPORTS = 10;
  localparam logic [2:0] OP_UNUSED6 = 3'd6;
  localparam logic [2:0] OP_UNUSED7 = 3'd7;

  // One row of the directed table
  typedef struct {
    dpaq_pkg::cmd_t c;
    bit             fixed;
    dpaq_pkg::res_t r;
  } dir_row_t;

  logic           clk;
  logic           rst;
  logic           start;
  logic           busy;
  dpaq_pkg::cmd_t cmd;
  logic           done;
  dpaq_pkg::res_t result;
  logic           cfg_we;
  logic [7:0]     cfg_data;

  // Queue model state
  logic [7:0] m_exp_store [EXP_DEPTH];
  logic [7:0] m_nrm_store [NRM_DEPTH];
  logic [2:0] m_exp_head, m_exp_tail;
  logic [4:0] m_nrm_head, m_nrm_tail;
  logic       m_mode;
  logic [7:0] m_empty_code;

  dpaq_pkg::res_t pending_results [$];
  dir_row_t       dir_rows [$];
  int             mismatch_count = 0;
  int             stall_cycles = 0;

  dual_priority_action_queue_top #(
    .EXPEDITED_DEPTH(EXP_DEPTH),
    .NORMAL_DEPTH   (NRM_DEPTH)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .done    (done),
    .result  (result),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [2:0] exp_held();
    exp_held = m_exp_tail - m_exp_head;
  endfunction

  function automatic logic [4:0] nrm_held();
    nrm_held = m_nrm_tail - m_nrm_head;
  endfunction

  // Apply one command to the model and return the beat it should produce
  function automatic dpaq_pkg::res_t predict_result(dpaq_pkg::cmd_t c);
    dpaq_pkg::res_t r;
    logic [2:0]     eq;
    logic [4:0]     nq;
    logic [7:0]     rel;
    logic [2:0]     es;
    logic [4:0]     ns;
    r = '0;
    eq = exp_held();
    nq = nrm_held();
    rel = c.position - eq;
    es = m_exp_head + c.position[2:0];
    ns = m_nrm_head + rel[4:0];
    case (c.operation)
      dpaq_pkg::OP_PUSH: begin
        if (m_mode) begin
          if (eq != 3'(EXP_DEPTH - 1)) begin
            m_exp_store[m_exp_tail] = c.action_in;
            m_exp_tail = m_exp_tail + 3'd1;
            r.push_accepted = 1'b1;
          end
        end else begin
          if (nq != 5'(NRM_DEPTH - 1)) begin
            m_nrm_store[m_nrm_tail] = c.action_in;
            m_nrm_tail = m_nrm_tail + 5'd1;
            r.push_accepted = 1'b1;
          end
        end
      end
      dpaq_pkg::OP_POP: begin
        if (eq != 3'd0) begin
          r.action_out = m_exp_store[m_exp_head];
          m_exp_head = m_exp_head + 3'd1;
        end else if (nq != 5'd0) begin
          r.action_out = m_nrm_store[m_nrm_head];
          m_nrm_head = m_nrm_head + 5'd1;
        end else begin
          r.action_out = m_empty_code;
        end
      end
      dpaq_pkg::OP_PEEK: begin
        if (c.position < eq) r.action_out = m_exp_store[es];
        else if (rel < nq) r.action_out = m_nrm_store[ns];
        else r.action_out = m_empty_code;
      end
      dpaq_pkg::OP_DELETE: begin
        if (c.position < eq) m_exp_store[es] = m_empty_code;
        else if (rel < nq) m_nrm_store[ns] = m_empty_code;
      end
      dpaq_pkg::OP_SET_EXP: m_mode = 1'b1;
      dpaq_pkg::OP_SET_NORMAL: m_mode = 1'b0;
      default: ;
    endcase
    r.expedited_count = exp_held();
    r.normal_count = nrm_held();
    r.expedited_mode = m_mode;
    return r;
  endfunction

  function automatic dpaq_pkg::res_t mk_res(logic [7:0] act, logic acc, logic [2:0] ec,
                                            logic [4:0] nc, logic mode);
    dpaq_pkg::res_t r;
    r.action_out = act;
    r.push_accepted = acc;
    r.expedited_count = ec;
    r.normal_count = nc;
    r.expedited_mode = mode;
    return r;
  endfunction

  task automatic add_row(logic [2:0] op, logic [7:0] act, logic [7:0] pos, bit fixed,
                         dpaq_pkg::res_t r);
    dir_row_t row;
    row.c.operation = op;
    row.c.action_in = act;
    row.c.position = pos;
    row.fixed = fixed;
    row.r = r;
    dir_rows.push_back(row);
  endtask

  // Random command; positions mostly near the held entries
  function automatic dpaq_pkg::cmd_t gen_cmd(int push_pct, int mode_pct);
    dpaq_pkg::cmd_t c;
    int             roll;
    int             held;
    held = exp_held() + nrm_held();
    c.action_in = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) c.position = 8'($urandom_range(0, 255));
    else c.position = 8'($urandom_range(0, held + 1));
    roll = $urandom_range(0, 99);
    if (roll < push_pct) begin
      c.operation = dpaq_pkg::OP_PUSH;
    end else if (roll < push_pct + mode_pct) begin
      c.operation = $urandom_range(0, 1) ? dpaq_pkg::OP_SET_EXP : dpaq_pkg::OP_SET_NORMAL;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 40) c.operation = dpaq_pkg::OP_POP;
      else if (roll < 70) c.operation = dpaq_pkg::OP_PEEK;
      else if (roll < 94) c.operation = dpaq_pkg::OP_DELETE;
      else c.operation = $urandom_range(0, 1) ? OP_UNUSED6 : OP_UNUSED7;
    end
    return c;
  endfunction

  // Present one command, hold it until accepted, queue its expected beat
  task automatic drive_beat(dpaq_pkg::cmd_t c, bit fixed, dpaq_pkg::res_t fixed_res);
    dpaq_pkg::res_t pred;
    cmd <= c;
    if (!start) start <= 1'b1;
    do @(posedge clk); while (busy);
    pred = predict_result(c);
    pending_results.push_back(fixed ? fixed_res : pred);
  endtask

  task automatic pause_sender(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_idle(bit idle_ok);
    if (idle_ok && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 7));
  endtask

  // Write the empty code once the block has drained
  task automatic write_empty_code(logic [7:0] v);
    pause_sender(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_data <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    m_empty_code = v;
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(logic [7:0] code, int push_pct, int mode_pct, int n, bit idle_ok);
    write_empty_code(code);
    repeat (n) begin
      maybe_idle(idle_ok && ($urandom_range(0, 9) != 0));
      drive_beat(gen_cmd(push_pct, mode_pct), 1'b0, '0);
    end
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      if (mismatch_count < MAX_REPORTS)
        $display("mismatch %s: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    dpaq_pkg::res_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("unexpected result beat: %0h", result);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("action_out", want.action_out, result.action_out);
        check_field("push_accepted", 8'(want.push_accepted), 8'(result.push_accepted));
        check_field("expedited_count", 8'(want.expedited_count),
                    8'(result.expedited_count));
        check_field("normal_count", 8'(want.normal_count), 8'(result.normal_count));
        check_field("expedited_mode", 8'(want.expedited_mode), 8'(result.expedited_mode));
      end
    end
  end

  // Abort when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    dpaq_pkg::res_t zero_res;
    start = 1'b0;
    cmd = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    rst = 1'b1;
    zero_res = '0;
    m_exp_head = '0;
    m_exp_tail = '0;
    m_nrm_head = '0;
    m_nrm_tail = '0;
    m_mode = 1'b0;
    m_empty_code = '0;
    foreach (m_exp_store[i]) m_exp_store[i] = '0;
    foreach (m_nrm_store[i]) m_nrm_store[i] = '0;

    // Empty queues, unused codes, then a few entries in both queues
    add_row(dpaq_pkg::OP_POP,        8'h00, 8'h00, 1'b1, zero_res);
    add_row(dpaq_pkg::OP_PEEK,       8'hFF, 8'h00, 1'b1, zero_res);
    add_row(dpaq_pkg::OP_PEEK,       8'h00, 8'hFF, 1'b1, zero_res);
    add_row(dpaq_pkg::OP_DELETE,     8'hFF, 8'h00, 1'b1, zero_res);
    add_row(OP_UNUSED6,              8'hFF, 8'hFF, 1'b1, zero_res);
    add_row(OP_UNUSED7,              8'h00, 8'h00, 1'b1, zero_res);
    add_row(dpaq_pkg::OP_PUSH,       8'hFF, 8'hFF, 1'b1,
            mk_res(8'h00, 1'b1, 3'd0, 5'd1, 1'b0));
    add_row(dpaq_pkg::OP_PUSH,       8'h00, 8'h00, 1'b1,
            mk_res(8'h00, 1'b1, 3'd0, 5'd2, 1'b0));
    add_row(dpaq_pkg::OP_SET_EXP,    8'h00, 8'h00, 1'b1,
            mk_res(8'h00, 1'b0, 3'd0, 5'd2, 1'b1));
    add_row(dpaq_pkg::OP_PUSH,       8'hA5, 8'h00, 1'b1,
            mk_res(8'h00, 1'b1, 3'd1, 5'd2, 1'b1));
    add_row(dpaq_pkg::OP_PUSH,       8'h5A, 8'hFF, 1'b1,
            mk_res(8'h00, 1'b1, 3'd2, 5'd2, 1'b1));
    add_row(dpaq_pkg::OP_PEEK,       8'h00, 8'h00, 1'b0, zero_res);
    add_row(dpaq_pkg::OP_PEEK,       8'h00, 8'h02, 1'b0, zero_res);
    add_row(dpaq_pkg::OP_PEEK,       8'h00, 8'h04, 1'b1,
            mk_res(8'h00, 1'b0, 3'd2, 5'd2, 1'b1));
    add_row(dpaq_pkg::OP_DELETE,     8'h00, 8'h01, 1'b0, zero_res);
    add_row(dpaq_pkg::OP_PEEK,       8'h00, 8'h01, 1'b0, zero_res);
    add_row(dpaq_pkg::OP_POP,        8'h00, 8'h00, 1'b0, zero_res);
    add_row(dpaq_pkg::OP_SET_NORMAL, 8'h00, 8'h00, 1'b0, zero_res);
    add_row(dpaq_pkg::OP_DELETE,     8'h00, 8'hFF, 1'b0, zero_res);
    add_row(dpaq_pkg::OP_POP,        8'h00, 8'h00, 1'b0, zero_res);
    add_row(dpaq_pkg::OP_POP,        8'h00, 8'h00, 1'b0, zero_res);
    add_row(dpaq_pkg::OP_POP,        8'h00, 8'h00, 1'b0, zero_res);
    add_row(dpaq_pkg::OP_POP,        8'h00, 8'h00, 1'b1, zero_res);

    // Hold reset, then release it
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      maybe_idle(1'b1);
      drive_beat(dir_rows[i].c, dir_rows[i].fixed, dir_rows[i].r);
    end

    // Random phases; the last runs without sender gaps
    run_phase(8'hFF, 60, 8, 110, 1'b1);
    run_phase(8'h01, 85, 2, 110, 1'b1);
    run_phase(8'($urandom_range(0, 255)), 30, 8, 110, 1'b1);
    run_phase(8'h00, 75, 3, 110, 1'b1);
    run_phase(8'h80, 50, 6, 110, 1'b0);

    // Drain and settle
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
